@@ hw/rtl/rcci_pkg.sv @@
// ----------------------------------------------------------------------------
// rcci_pkg
// Shared types and constants for the rate curve inverse core.
// ----------------------------------------------------------------------------
package rcci_pkg;

  // Number of unrolled bisection steps
  localparam int BISECT_STEPS = 16;

  // Register reset values
  localparam logic [10:0] CENTER_RESET = 11'd70;
  localparam logic [10:0] MAX_RESET    = 11'd670;
  localparam logic [20:0] EXPO_RESET   = 21'd891702;

  // Arithmetic constants
  localparam logic [6:0]  EXPO_MAX     = 7'd100;
  localparam logic [17:0] CENTER_SCALE = 18'd100;
  localparam logic [18:0] TARGET_SCALE = 19'd409600;
  localparam logic [15:0] MASK_INIT    = 16'h8000;

  typedef enum logic [1:0] {
    AXIS_ROLL  = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_YAW   = 2'd2,
    AXIS_NONE  = 2'd3
  } rcci_axis_e;

  typedef enum logic [2:0] {
    REG_CENTER_ROLL  = 3'd0,
    REG_CENTER_PITCH = 3'd1,
    REG_CENTER_YAW   = 3'd2,
    REG_MAX_ROLL     = 3'd3,
    REG_MAX_PITCH    = 3'd4,
    REG_MAX_YAW      = 3'd5,
    REG_EXPO         = 3'd6
  } rcci_reg_e;

  // Item state carried along the bisection pipeline
  typedef struct packed {
    logic [15:0]        lo;        // current lower bound
    logic [15:0]        mask;      // probe bit of this step
    logic               neg;
    logic               err;
    logic               zero;
    logic [17:0]        c100;      // 100 * center
    logic signed [11:0] mvmt;      // max - center
    logic [6:0]         expo;
    logic [6:0]         expo_inv;  // 100 - expo
    logic [33:0]        target;    // magnitude * 409600
  } rcci_item_t;

endpackage

@@ hw/rtl/rcci_in_if.sv @@
// ----------------------------------------------------------------------------
// rcci_in_if
// Rate request channel: valid/ready with rate and axis payload.
// ----------------------------------------------------------------------------
interface rcci_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rate_in;
  logic [1:0]         axis_sel;

  modport source (output valid, output rate_in, output axis_sel, input ready);
  modport sink   (input valid, input rate_in, input axis_sel, output ready);
endinterface

@@ hw/rtl/rcci_out_if.sv @@
// ----------------------------------------------------------------------------
// rcci_out_if
// Stick result channel: valid/ready with stick and error payload.
// ----------------------------------------------------------------------------
interface rcci_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] stick_out;
  logic               axis_error;

  modport source (output valid, output stick_out, output axis_error, input ready);
  modport sink   (input valid, input stick_out, input axis_error, output ready);
endinterface

@@ hw/rtl/rcci_step.sv @@
// ----------------------------------------------------------------------------
// rcci_step
// One bisection step in six register stages: evaluates the rate curve at
// lo | mask, compares against the target and updates the lower bound.
// ----------------------------------------------------------------------------
module rcci_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rcci_pkg::rcci_item_t item_i,
  output logic                valid_o,
  output rcci_pkg::rcci_item_t item_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  rcci_pkg::rcci_item_t it1_q, it2_q, it3_q, it4_q, it5_q, it6_q;
  rcci_pkg::rcci_item_t it6_d;

  logic [15:0] x0;
  logic [31:0] sq0;
  logic [33:0] cx_d;
  logic [15:0] x1_q, x2_1_q;
  logic [33:0] cx1_q;

  logic [31:0] sq1;
  logic [22:0] a_d;
  logic [15:0] x2_q, x2_2_q, x4_2_q;
  logic [22:0] a2_q;
  logic [33:0] cx2_q;

  logic [31:0] sq2;
  logic [15:0] x3_q, x6_3_q;
  logic [22:0] a3_q;
  logic [33:0] cx3_q;

  logic [23:0]        s_d;
  logic [15:0]        x4_q;
  logic [23:0]        s4_q;
  logic [33:0]        cx4_q;

  logic signed [36:0] m_d;
  logic [15:0]        x5_q;
  logic signed [36:0] m5_q;
  logic [33:0]        cx5_q;

  logic signed [37:0] curve;
  logic               below;

  // stage 1: x^2 and center term
  assign x0   = item_i.lo | item_i.mask;
  assign sq0  = 32'(x0) * 32'(x0);
  assign cx_d = 34'(item_i.c100) * 34'(x0);

  // stage 2: x^4 and linear-in-x2 term
  assign sq1 = 32'(x2_1_q) * 32'(x2_1_q);
  assign a_d = 23'(it1_q.expo_inv) * 23'(x2_1_q);

  // stage 3: x^6
  assign sq2 = 32'(x4_2_q) * 32'(x2_2_q);

  // stage 4: expo blend
  assign s_d = 24'(a3_q) + 24'(23'(it3_q.expo) * 23'(x6_3_q));

  // stage 5: movement scale
  assign m_d = 37'(it4_q.mvmt) * $signed({13'd0, s4_q});

  // stage 6: compare and bound update
  assign curve = $signed({4'd0, cx5_q}) + 38'(m5_q);
  assign below = curve < $signed({4'd0, it5_q.target});

  always_comb begin
    it6_d      = it5_q;
    it6_d.lo   = below ? x5_q : it5_q.lo;
    it6_d.mask = it5_q.mask >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      x1_q   <= x0;
      x2_1_q <= sq0[31:16];
      cx1_q  <= cx_d;

      it2_q  <= it1_q;
      x2_q   <= x1_q;
      x2_2_q <= x2_1_q;
      x4_2_q <= sq1[31:16];
      a2_q   <= a_d;
      cx2_q  <= cx1_q;

      it3_q  <= it2_q;
      x3_q   <= x2_q;
      x6_3_q <= sq2[31:16];
      a3_q   <= a2_q;
      cx3_q  <= cx2_q;

      it4_q  <= it3_q;
      x4_q   <= x3_q;
      s4_q   <= s_d;
      cx4_q  <= cx3_q;

      it5_q  <= it4_q;
      x5_q   <= x4_q;
      m5_q   <= m_d;
      cx5_q  <= cx4_q;

      it6_q  <= it6_d;
    end
  end

  assign valid_o = v6_q;
  assign item_o  = it6_q;

endmodule

@@ hw/rtl/rc_rate_curve_inverse_core.sv @@
// ----------------------------------------------------------------------------
// rc_rate_curve_inverse_core
// Inverts the actual-rates stick curve: body rate in, stick deflection out,
// by a fully unrolled, pipelined fixed-point bisection.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          beat payload
//  -------   ---  -----------------  -------------------------------------
//  rate_i    in   valid/ready        rate_in s16 (1/16 deg/s), axis_sel u2
//  stick_o   out  valid/ready        stick_out s17 (2^-16), axis_error u1
//  apb       in   psel/penable/pwr.  7 registers at 4*i, 32-bit data
//
//  One beat per cycle sustained while the skid register is empty. From
//  accept to output valid: 3 front-end stages, 16 bisection steps of 6
//  stages each (set by the multiply chain x^2, x^4, x^6, blend, movement,
//  compare), and the output register. Reset clears valid bits and config
//  registers; no clearing pass. A stalled output parks one beat in a skid
//  register, and the whole pipeline freezes only while the skid is full.
//
module rc_rate_curve_inverse_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcci_in_if.sink     rate_i,
  rcci_out_if.source  stick_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [10:0] center_q [3];
  logic [10:0] max_q    [3];
  logic [20:0] expo_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= rcci_pkg::CENTER_RESET;
      center_q[1] <= rcci_pkg::CENTER_RESET;
      center_q[2] <= rcci_pkg::CENTER_RESET;
      max_q[0]    <= rcci_pkg::MAX_RESET;
      max_q[1]    <= rcci_pkg::MAX_RESET;
      max_q[2]    <= rcci_pkg::MAX_RESET;
      expo_q      <= rcci_pkg::EXPO_RESET;
    end else if (cfg_wr) begin
      case (rcci_pkg::rcci_reg_e'(paddr[4:2]))
        rcci_pkg::REG_CENTER_ROLL:  center_q[0] <= pwdata[10:0];
        rcci_pkg::REG_CENTER_PITCH: center_q[1] <= pwdata[10:0];
        rcci_pkg::REG_CENTER_YAW:   center_q[2] <= pwdata[10:0];
        rcci_pkg::REG_MAX_ROLL:     max_q[0]    <= pwdata[10:0];
        rcci_pkg::REG_MAX_PITCH:    max_q[1]    <= pwdata[10:0];
        rcci_pkg::REG_MAX_YAW:      max_q[2]    <= pwdata[10:0];
        rcci_pkg::REG_EXPO:         expo_q      <= pwdata[20:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_comb begin
    case (rcci_pkg::rcci_reg_e'(paddr[4:2]))
      rcci_pkg::REG_CENTER_ROLL:  prdata = {21'd0, center_q[0]};
      rcci_pkg::REG_CENTER_PITCH: prdata = {21'd0, center_q[1]};
      rcci_pkg::REG_CENTER_YAW:   prdata = {21'd0, center_q[2]};
      rcci_pkg::REG_MAX_ROLL:     prdata = {21'd0, max_q[0]};
      rcci_pkg::REG_MAX_PITCH:    prdata = {21'd0, max_q[1]};
      rcci_pkg::REG_MAX_YAW:      prdata = {21'd0, max_q[2]};
      rcci_pkg::REG_EXPO:         prdata = {11'd0, expo_q};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: whole pipeline advances unless the skid register is full
  // --------------------------------------------------------------------------
  logic en;
  logic skid_v_q, out_v_q;

  assign en           = ~skid_v_q;
  assign rate_i.ready = en;

  // --------------------------------------------------------------------------
  // Front end F0: magnitude and sign
  // --------------------------------------------------------------------------
  logic [15:0] raw_u;
  logic [15:0] mag_d;
  logic        f0_v_q;
  logic [15:0] f0_mag_q;
  logic        f0_neg_q;
  logic [1:0]  f0_axis_q;

  assign raw_u = rate_i.rate_in;
  assign mag_d = raw_u[15] ? (~raw_u + 16'd1) : raw_u;

  // --------------------------------------------------------------------------
  // F1: axis select, clamp, derived curve coefficients
  // --------------------------------------------------------------------------
  logic [10:0]        sel_center, sel_max;
  logic [6:0]         sel_expo_raw, sel_expo;
  logic [14:0]        limit;
  logic [15:0]        magc_d;
  logic               f1_v_q;
  logic [15:0]        f1_magc_q;
  logic               f1_neg_q, f1_err_q;
  logic [17:0]        f1_c100_q;
  logic signed [11:0] f1_mvmt_q;
  logic [6:0]         f1_expo_q, f1_expo_inv_q;

  always_comb begin
    case (rcci_pkg::rcci_axis_e'(f0_axis_q))
      rcci_pkg::AXIS_ROLL: begin
        sel_center   = center_q[0];
        sel_max      = max_q[0];
        sel_expo_raw = expo_q[6:0];
      end
      rcci_pkg::AXIS_PITCH: begin
        sel_center   = center_q[1];
        sel_max      = max_q[1];
        sel_expo_raw = expo_q[13:7];
      end
      rcci_pkg::AXIS_YAW: begin
        sel_center   = center_q[2];
        sel_max      = max_q[2];
        sel_expo_raw = expo_q[20:14];
      end
      default: begin  // invalid axis, result forced to zero later
        sel_center   = '0;
        sel_max      = '0;
        sel_expo_raw = '0;
      end
    endcase
  end

  assign sel_expo = (sel_expo_raw > rcci_pkg::EXPO_MAX) ? rcci_pkg::EXPO_MAX : sel_expo_raw;
  assign limit    = {sel_max, 4'b0000};
  assign magc_d   = (f0_mag_q > {1'b0, limit}) ? {1'b0, limit} : f0_mag_q;

  // --------------------------------------------------------------------------
  // F2: target scale, build the item for the bisection chain
  // --------------------------------------------------------------------------
  logic                 f2_v_q;
  rcci_pkg::rcci_item_t f2_item_q;
  rcci_pkg::rcci_item_t f2_item_d;

  always_comb begin
    f2_item_d          = '0;
    f2_item_d.lo       = '0;
    f2_item_d.mask     = rcci_pkg::MASK_INIT;
    f2_item_d.neg      = f1_neg_q;
    f2_item_d.err      = f1_err_q;
    f2_item_d.zero     = (f1_magc_q == '0);
    f2_item_d.c100     = f1_c100_q;
    f2_item_d.mvmt     = f1_mvmt_q;
    f2_item_d.expo     = f1_expo_q;
    f2_item_d.expo_inv = f1_expo_inv_q;
    f2_item_d.target   = 34'(f1_magc_q) * 34'(rcci_pkg::TARGET_SCALE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (en) begin
      f0_v_q <= rate_i.valid;
      f1_v_q <= f0_v_q;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_mag_q      <= mag_d;
      f0_neg_q      <= raw_u[15];
      f0_axis_q     <= rate_i.axis_sel;

      f1_magc_q     <= magc_d;
      f1_neg_q      <= f0_neg_q;
      f1_err_q      <= (f0_axis_q == rcci_pkg::AXIS_NONE);
      f1_c100_q     <= 18'(sel_center) * rcci_pkg::CENTER_SCALE;
      f1_mvmt_q     <= $signed({1'b0, sel_max}) - $signed({1'b0, sel_center});
      f1_expo_q     <= sel_expo;
      f1_expo_inv_q <= rcci_pkg::EXPO_MAX - sel_expo;

      f2_item_q     <= f2_item_d;
    end
  end

  // --------------------------------------------------------------------------
  // Bisection chain: one step per bit, MSB first
  // --------------------------------------------------------------------------
  logic                 step_v    [rcci_pkg::BISECT_STEPS + 1];
  rcci_pkg::rcci_item_t step_item [rcci_pkg::BISECT_STEPS + 1];

  assign step_v[0]    = f2_v_q;
  assign step_item[0] = f2_item_q;

  for (genvar g = 0; g < rcci_pkg::BISECT_STEPS; g++) begin : g_step
    rcci_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (step_v[g]),
      .item_i  (step_item[g]),
      .valid_o (step_v[g+1]),
      .item_o  (step_item[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Result: restore sign, zero on error or zero target; output + skid regs
  // --------------------------------------------------------------------------
  rcci_pkg::rcci_item_t tail;
  logic [16:0]          lo_ext;
  logic [16:0]          res_stick;
  logic                 push;

  assign tail      = step_item[rcci_pkg::BISECT_STEPS];
  assign lo_ext    = {1'b0, tail.lo};
  assign res_stick = (tail.err | tail.zero) ? 17'd0 :
                     (tail.neg ? (~lo_ext + 17'd1) : lo_ext);
  assign push      = step_v[rcci_pkg::BISECT_STEPS] & en;

  logic        out_v_d, skid_v_d;
  logic        load_from_skid, load_from_push, load_skid;
  logic [16:0] out_stick_q, skid_stick_q;
  logic        out_err_q, skid_err_q;
  logic        pop;

  assign pop = out_v_q & stick_o.ready;

  always_comb begin
    out_v_d        = out_v_q;
    skid_v_d       = skid_v_q;
    load_from_skid = 1'b0;
    load_from_push = 1'b0;
    load_skid      = 1'b0;
    if (pop || !out_v_q) begin
      if (skid_v_q) begin
        load_from_skid = 1'b1;
        skid_v_d       = 1'b0;
        out_v_d        = 1'b1;
      end else begin
        load_from_push = push;
        out_v_d        = push;
      end
    end else if (push) begin
      load_skid = 1'b1;
      skid_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_from_skid) begin
      out_stick_q <= skid_stick_q;
      out_err_q   <= skid_err_q;
    end else if (load_from_push) begin
      out_stick_q <= res_stick;
      out_err_q   <= tail.err;
    end
    if (load_skid) begin
      skid_stick_q <= res_stick;
      skid_err_q   <= tail.err;
    end
  end

  assign stick_o.valid      = out_v_q;
  assign stick_o.stick_out  = $signed(out_stick_q);
  assign stick_o.axis_error = out_err_q;

`ifndef SYNTH
  // skid holds a beat only behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register valid with empty output register");

  // skid fills only when the output beat was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !stick_o.ready))
    else $error("skid register filled without output stall");

  // pipeline tail frozen while the skid register is full
  a_tail_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(step_v[rcci_pkg::BISECT_STEPS]))
    else $error("pipeline moved during stall");

  // invalid axis always reports a zero stick
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_err_q) |-> (out_stick_q == 17'd0))
    else $error("axis error beat with nonzero stick");
`endif

endmodule
